/* hw/rtl/assert_macros.svh */
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/depq_pkg.sv */
// Types, codes and constants of the double-ended priority queue.
package depq_pkg;

    localparam int KEY_W          = 24;
    localparam int PRIO_W         = 24;
    localparam int CMD_W          = 2;
    localparam int DEF_CAPACITY   = 64;
    localparam int GROUP_SIZE     = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SERVE_MAX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SERVE_MIN = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [KEY_W-1:0]  client_key;
        logic [PRIO_W-1:0] priority_req;
    } t_depq_in;

    typedef struct packed {
        logic [KEY_W-1:0] served_key;
        logic             queue_was_empty;
        logic             insert_dropped;
    } t_depq_out;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
    } t_depq_slot;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic              ins;
        logic              serve_min;
        logic              serve_max;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
    } t_depq_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } t_state;

endpackage

/* hw/rtl/depq_cell.sv */
// One storage cell of the sorted chain: holds one entry, shifts with its neighbors.
module depq_cell import depq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_depq_ctl         i_ctl,
    input  t_depq_slot        i_lo,
    input  logic              i_lo_take,
    input  t_depq_slot        i_hi,
    output t_depq_slot        o_slot,
    output logic              o_take,
    output logic [KEY_W-1:0]  o_top_key
);

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [PRIO_W-1:0] r_prio;
    logic              n_valid;
    logic [KEY_W-1:0]  n_key;
    logic [PRIO_W-1:0] n_prio;
    logic              w_top;

    assign o_slot    = '{valid: r_valid, key: r_key, prio: r_prio};
    // new entry belongs here or below: slot empty or holds a strictly greater priority
    assign o_take    = !r_valid || (r_prio > i_ctl.prio);
    assign w_top     = r_valid && !i_hi.valid;
    assign o_top_key = w_top ? r_key : '0;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_prio  = r_prio;
        if (i_ctl.ins) begin
            if (i_lo_take) begin
                n_valid = i_lo.valid;
                n_key   = i_lo.key;
                n_prio  = i_lo.prio;
            end else if (o_take) begin
                n_valid = 1'b1;
                n_key   = i_ctl.key;
                n_prio  = i_ctl.prio;
            end
        end else if (i_ctl.serve_min) begin
            n_valid = i_hi.valid;
            n_key   = i_hi.key;
            n_prio  = i_hi.prio;
        end else if (i_ctl.serve_max) begin
            if (w_top) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_prio <= n_prio;
    end

endmodule

/* hw/rtl/double_ended_priority_queue.sv */
// Double-ended priority queue built as a sorted chain of storage cells.
//
// The queue holds up to CAPACITY (key, priority) entries in a row of cells kept in
// ascending priority order, the lowest at cell 0 and occupied cells always packed at
// the bottom of the row. A command is a transfer on the i_item port, taken at a
// rising edge with start high and busy low. Insert (no result unless the queue is
// full) places the entry after every entry of equal priority; serve-max returns the
// top entry, serve-min the bottom entry. Serving an empty queue returns key 0 with
// queue_was_empty set; an insert into a full queue is dropped and returns a result
// with insert_dropped set. An unused command code does nothing and returns nothing.
// After its transfer, each command keeps the block busy through a shift state, in
// which all cells compare and shift in parallel with their neighbors, and a gather
// state, in which the top entry's key is gathered through a registered two-level
// OR tree over groups of eight cells. The result appears on o_result with o_strobe
// high for exactly one cycle, after the gather state; busy is already low in that
// cycle, so the next command can be taken at its end, but none before. The receiver
// cannot stall the result: it must take it in that cycle. No clearing pass runs
// after reset; the cells' valid bits are cleared at once.
module double_ended_priority_queue import depq_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_depq_in  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_depq_out o_result
);

    `include "assert_macros.svh"

    localparam int GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    t_state            r_state;
    t_state            n_state;
    logic [CMD_W-1:0]  r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [PRIO_W-1:0] r_prio;

    // result bookkeeping captured at the end of the shift cycle
    logic              r_has_res;
    logic              r_from_max;
    logic              r_empty_hit;
    logic              r_drop;
    logic [KEY_W-1:0]  r_min_key;
    logic [KEY_W-1:0]  r_grp [GROUPS];

    logic              r_strobe;
    t_depq_out         r_result;

    t_depq_ctl         w_ctl;
    t_depq_slot        w_slot [CAPACITY];
    logic              w_take [CAPACITY];
    logic [KEY_W-1:0]  w_top  [CAPACITY];
    logic [KEY_W-1:0]  w_grp  [GROUPS];
    logic [KEY_W-1:0]  w_max_key;
    logic              w_full;
    logic              w_empty;
    logic              w_accept;
    logic              w_exec;
    logic              w_is_ins;
    logic              w_is_serve;

    assign w_accept   = start && !busy;
    assign w_full     = w_slot[CAPACITY-1].valid;
    assign w_empty    = !w_slot[0].valid;
    assign w_exec     = (r_state == S_EXEC);
    assign w_is_ins   = (r_cmd == CMD_INSERT);
    assign w_is_serve = (r_cmd == CMD_SERVE_MAX) || (r_cmd == CMD_SERVE_MIN);

    // Broadcast the operation to all cells; drop inserts into a full row and serves of
    // an empty one.
    always_comb begin
        w_ctl.ins       = w_exec && w_is_ins && !w_full;
        w_ctl.serve_min = w_exec && (r_cmd == CMD_SERVE_MIN) && !w_empty;
        w_ctl.serve_max = w_exec && (r_cmd == CMD_SERVE_MAX) && !w_empty;
        w_ctl.key       = r_key;
        w_ctl.prio      = r_prio;
    end

    // Cell chain: each cell sees its lower and upper neighbor.
    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        t_depq_slot w_lo;
        t_depq_slot w_hi;
        logic       w_lo_take;

        if (c == 0) begin : g_bottom
            assign w_lo      = '0;
            assign w_lo_take = 1'b0;
        end else begin : g_inner_lo
            assign w_lo      = w_slot[c-1];
            assign w_lo_take = w_take[c-1];
        end

        if (c == CAPACITY - 1) begin : g_topmost
            assign w_hi = '0;
        end else begin : g_inner_hi
            assign w_hi = w_slot[c+1];
        end

        depq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_lo      (w_lo),
            .i_lo_take (w_lo_take),
            .i_hi      (w_hi),
            .o_slot    (w_slot[c]),
            .o_take    (w_take[c]),
            .o_top_key (w_top[c])
        );
    end

    // First level of the top-key tree: only the highest occupied cell drives its key
    // and all other cells drive zero, so an OR per group of cells picks it out.
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            w_grp[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < CAPACITY) begin
                    w_grp[g] = w_grp[g] | w_top[g * GROUP_SIZE + j];
                end
            end
        end
    end

    // Second level over the registered group results.
    always_comb begin
        w_max_key = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_max_key = w_max_key | r_grp[g];
        end
    end

    // Sequencer: idle, then a shift state, then a gather state.
    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_REDUCE;
            end
            S_REDUCE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the command fields for the duration of the command.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_item.command;
            r_key  <= i_item.client_key;
            r_prio <= i_item.priority_req;
        end
    end

    // Capture the outcome and the pre-shift keys at the end of the shift cycle.
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_from_max  <= (r_cmd == CMD_SERVE_MAX);
            r_empty_hit <= w_is_serve && w_empty;
            r_drop      <= w_is_ins && w_full;
            r_min_key   <= w_slot[0].key;
            for (int g = 0; g < GROUPS; g++) begin
                r_grp[g] <= w_grp[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_res <= 1'b0;
        end else if (w_exec) begin
            r_has_res <= w_is_serve || (w_is_ins && w_full);
        end
    end

    // Present the result for one cycle; the receiver cannot hold it off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_REDUCE) && r_has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_REDUCE) begin
            r_result.queue_was_empty <= r_empty_hit;
            r_result.insert_dropped  <= r_drop;
            if (r_empty_hit || r_drop) begin
                r_result.served_key <= '0;
            end else if (r_from_max) begin
                r_result.served_key <= w_max_key;
            end else begin
                r_result.served_key <= r_min_key;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // An occupied cell 1 implies an occupied cell 0, as occupied cells stay packed at the bottom.
    `ASSERT_IMPLIES(a_packed_bottom, i_clk, i_rst_n, w_slot[1].valid, w_slot[0].valid)
    // A transfer always starts the shift cycle.
    `ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC)
    // A result never reports both an empty serve and a dropped insert.
    `ASSERT_IMPLIES(a_one_flag, i_clk, i_rst_n, o_strobe,
        !(o_result.queue_was_empty && o_result.insert_dropped))
    // A result is never presented during the gather cycle.
    `ASSERT_IMPLIES(a_strobe_idle, i_clk, i_rst_n, o_strobe, r_state != S_REDUCE)

endmodule
